/* rtl/core/bdms_pkg.sv */
// Types and constants shared by the baud divisor and mode select pipeline.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package bdms_pkg;

    localparam int unsigned OscW   = 27;
    localparam int unsigned BaudW  = 24;
    localparam int unsigned ErrW   = 14;
    localparam int unsigned DivW   = 16;
    localparam int unsigned QuoW   = 26;   // rounded osc/(x*baud), at most 2^25
    localparam int unsigned MW     = 31;   // x*baud*(n+1) stays below 2^31
    localparam int unsigned NumW   = 45;   // |osc - m| * 10000
    localparam int unsigned Lanes  = 3;

    localparam logic [OscW-1:0] OSC_RESET = 27'd48000000;
    localparam logic [ErrW-1:0] ERR_FULL  = 14'd10000;
    localparam logic [ErrW-1:0] ERR_SCALE = 14'd10000;
    localparam logic [DivW-1:0] N8_LIMIT  = 16'd255;
    localparam logic [DivW-1:0] N16_LIMIT = 16'd65535;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_X64,
        MODE_X16,
        MODE_X4
    } t_mode;

    typedef struct packed {
        logic [BaudW-1:0] desired_baud;
        logic [ErrW-1:0]  max_error_hundredths;
    } t_in;

    typedef struct packed {
        logic            config_ok;
        logic            brg16_sel;
        logic            brgh_sel;
        logic [DivW-1:0] divisor;
        logic [ErrW-1:0] error_hundredths;
    } t_out;

    // Per-transaction control carried alongside the arithmetic
    typedef struct packed {
        logic [ErrW-1:0] limit;
        logic            zero_baud;
    } t_side;

    // Per-lane divisor and its range check
    typedef struct packed {
        logic [DivW-1:0] n;
        logic            n_ok;
    } t_lane;

    // Prescaler shift per lane: lane 0 is x64, lane 1 x16, lane 2 x4
    function automatic int unsigned mode_shift(input int unsigned lane);
        int unsigned s;
        case (lane)
            0:       s = 6;
            1:       s = 4;
            default: s = 2;
        endcase
        return s;
    endfunction

endpackage

/* rtl/core/bdms_qdiv.sv */
// Bit-serial pipelined divider: osc / baud, one quotient bit per stage.
// Depends on bdms_pkg.
`timescale 1ns / 1ps
module bdms_qdiv
    import bdms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_in               i_data,
    input  logic [OscW-1:0]   i_osc,
    output logic              o_valid,
    output logic [OscW-1:0]   o_quo,
    output logic [BaudW-1:0]  o_baud,
    output t_side             o_side
);

    logic              r_v    [0:OscW];
    logic [BaudW-1:0]  r_b    [0:OscW];
    logic [BaudW-1:0]  r_rem  [0:OscW];
    logic [OscW-1:0]   r_quo  [0:OscW];
    t_side             r_side [0:OscW];
    logic [BaudW-1:0]  n_rem  [0:OscW-1];
    logic [OscW-1:0]   n_quo  [0:OscW-1];

    // One restoring step per stage, most significant dividend bit first
    always_comb begin
        logic [BaudW:0] trial;
        for (int k = 0; k < OscW; k++) begin
            trial = {r_rem[k], i_osc[OscW-1-k]};
            if (trial >= {1'b0, r_b[k]}) begin
                n_rem[k] = BaudW'(trial - {1'b0, r_b[k]});
                n_quo[k] = {r_quo[k][OscW-2:0], 1'b1};
            end else begin
                n_rem[k] = trial[BaudW-1:0];
                n_quo[k] = {r_quo[k][OscW-2:0], 1'b0};
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= OscW; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 0; k < OscW; k++) r_v[k+1] <= r_v[k];
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b[0]              <= i_data.desired_baud;
            r_rem[0]            <= '0;
            r_quo[0]            <= '0;
            r_side[0].limit     <= i_data.max_error_hundredths;
            r_side[0].zero_baud <= (i_data.desired_baud == '0);
            for (int k = 0; k < OscW; k++) begin
                r_b[k+1]    <= r_b[k];
                r_rem[k+1]  <= n_rem[k];
                r_quo[k+1]  <= n_quo[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_v[OscW];
    assign o_quo   = r_quo[OscW];
    assign o_baud  = r_b[OscW];
    assign o_side  = r_side[OscW];

endmodule

/* rtl/core/bdms_front.sv */
// Per-prescaler rounding, product and scaled error numerator, three stages.
// Depends on bdms_pkg.
`timescale 1ns / 1ps
module bdms_front
    import bdms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [OscW-1:0]   i_quo,
    input  logic [BaudW-1:0]  i_baud,
    input  t_side             i_side,
    input  logic [OscW-1:0]   i_osc,
    output logic              o_valid,
    output logic [NumW-1:0]   o_num  [0:Lanes-1],
    output logic [MW-1:0]     o_m    [0:Lanes-1],
    output t_lane             o_lane [0:Lanes-1],
    output t_side             o_side
);

    logic [2:0]               r_v;
    t_side                    r_side [0:2];
    logic [BaudW-1:0]         r_b1;
    logic [QuoW-1:0]          r_nq1  [0:Lanes-1];
    t_lane                    r_ln1  [0:Lanes-1];
    logic [MW-1:0]            r_m2   [0:Lanes-1];
    t_lane                    r_ln2  [0:Lanes-1];
    logic [MW-1:0]            r_m3   [0:Lanes-1];
    logic [NumW-1:0]          r_num3 [0:Lanes-1];
    t_lane                    r_ln3  [0:Lanes-1];
    logic [QuoW-1:0]          n_nq1  [0:Lanes-1];
    t_lane                    n_ln1  [0:Lanes-1];
    logic [MW-1:0]            n_m2   [0:Lanes-1];
    logic [NumW-1:0]          n_num3 [0:Lanes-1];

    // Round osc/(x*baud) half up from osc/baud, then n = q - 1 clamped at 0
    always_comb begin
        logic [OscW:0]   sum;
        logic [QuoW-1:0] q;
        logic [QuoW-1:0] n;
        for (int l = 0; l < Lanes; l++) begin
            sum = {1'b0, i_quo} + ((OscW+1)'(1) << (mode_shift(l) - 1));
            q   = QuoW'(sum >> mode_shift(l));
            n   = (q == '0) ? '0 : q - QuoW'(1);
            n_nq1[l]   = (q == '0) ? QuoW'(1) : q;
            n_ln1[l].n = n[DivW-1:0];
            if (l == 0) n_ln1[l].n_ok = (n < QuoW'(N8_LIMIT));
            else        n_ln1[l].n_ok = (n < QuoW'(N16_LIMIT));
        end
    end

    // m = x * baud * (n + 1)
    always_comb begin
        logic [BaudW+QuoW-1:0] prod;
        for (int l = 0; l < Lanes; l++) begin
            prod    = (BaudW+QuoW)'(r_b1) * (BaudW+QuoW)'(r_nq1[l]);
            n_m2[l] = MW'(prod << mode_shift(l));
        end
    end

    // Scale |osc - m| by 10000
    always_comb begin
        logic [MW-1:0] diff;
        for (int l = 0; l < Lanes; l++) begin
            if (MW'(i_osc) >= r_m2[l]) diff = MW'(i_osc) - r_m2[l];
            else                       diff = r_m2[l] - MW'(i_osc);
            n_num3[l] = NumW'(diff) * NumW'(ERR_SCALE);
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b1      <= i_baud;
            r_side[0] <= i_side;
            r_side[1] <= r_side[0];
            r_side[2] <= r_side[1];
            for (int l = 0; l < Lanes; l++) begin
                r_nq1[l]  <= n_nq1[l];
                r_ln1[l]  <= n_ln1[l];
                r_m2[l]   <= n_m2[l];
                r_ln2[l]  <= r_ln1[l];
                r_m3[l]   <= r_m2[l];
                r_num3[l] <= n_num3[l];
                r_ln3[l]  <= r_ln2[l];
            end
        end
    end

    assign o_valid = r_v[2];
    assign o_side  = r_side[2];
    always_comb begin
        for (int l = 0; l < Lanes; l++) begin
            o_num[l]  = r_num3[l];
            o_m[l]    = r_m3[l];
            o_lane[l] = r_ln3[l];
        end
    end

endmodule

/* rtl/core/bdms_ediv.sv */
// Pipelined error divider: num / m for three lanes, one quotient bit a stage.
// Depends on bdms_pkg; the quotient never exceeds 10000, so 14 bits suffice.
`timescale 1ns / 1ps
module bdms_ediv
    import bdms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NumW-1:0]   i_num  [0:Lanes-1],
    input  logic [MW-1:0]     i_m    [0:Lanes-1],
    input  t_lane             i_lane [0:Lanes-1],
    input  t_side             i_side,
    output logic              o_valid,
    output logic [ErrW-1:0]   o_err  [0:Lanes-1],
    output t_lane             o_lane [0:Lanes-1],
    output t_side             o_side
);

    logic              r_v    [1:ErrW];
    t_side             r_side [1:ErrW];
    logic [NumW-1:0]   r_rem  [1:ErrW][0:Lanes-1];
    logic [MW-1:0]     r_m    [1:ErrW][0:Lanes-1];
    logic [ErrW-1:0]   r_quo  [1:ErrW][0:Lanes-1];
    t_lane             r_lane [1:ErrW][0:Lanes-1];
    logic [NumW-1:0]   n_rem  [0:ErrW-1][0:Lanes-1];
    logic [ErrW-1:0]   n_quo  [0:ErrW-1][0:Lanes-1];

    // Restoring step: compare against m aligned to this stage's bit
    always_comb begin
        logic [NumW-1:0] rem;
        logic [MW-1:0]   dv;
        logic [ErrW-1:0] quo;
        logic [NumW-1:0] sh;
        for (int k = 0; k < ErrW; k++) begin
            for (int l = 0; l < Lanes; l++) begin
                if (k == 0) begin
                    rem = i_num[l];
                    dv  = i_m[l];
                    quo = '0;
                end else begin
                    rem = r_rem[k][l];
                    dv  = r_m[k][l];
                    quo = r_quo[k][l];
                end
                sh = NumW'(dv) << (ErrW - 1 - k);
                if (rem >= sh) begin
                    n_rem[k][l] = rem - sh;
                    n_quo[k][l] = {quo[ErrW-2:0], 1'b1};
                end else begin
                    n_rem[k][l] = rem;
                    n_quo[k][l] = {quo[ErrW-2:0], 1'b0};
                end
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= ErrW; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[1] <= i_valid;
            for (int k = 1; k < ErrW; k++) r_v[k+1] <= r_v[k];
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[1] <= i_side;
            for (int k = 1; k < ErrW; k++) r_side[k+1] <= r_side[k];
            for (int l = 0; l < Lanes; l++) begin
                r_rem[1][l]  <= n_rem[0][l];
                r_quo[1][l]  <= n_quo[0][l];
                r_m[1][l]    <= i_m[l];
                r_lane[1][l] <= i_lane[l];
                for (int k = 1; k < ErrW; k++) begin
                    r_rem[k+1][l]  <= n_rem[k][l];
                    r_quo[k+1][l]  <= n_quo[k][l];
                    r_m[k+1][l]    <= r_m[k][l];
                    r_lane[k+1][l] <= r_lane[k][l];
                end
            end
        end
    end

    assign o_valid = r_v[ErrW];
    assign o_side  = r_side[ErrW];
    always_comb begin
        for (int l = 0; l < Lanes; l++) begin
            o_err[l]  = r_quo[ErrW][l];
            o_lane[l] = r_lane[ErrW][l];
        end
    end

endmodule

/* rtl/core/baud_divisor_mode_select.sv */
// Data passes through qdiv, front, ediv and the output register, in that order.
// Throughput: one transaction per cycle unless the output is stalled; osc/baud is
// a 27-stage bit-serial divider and the three error quotients a 14-stage divider,
// all fully pipelined. The whole pipeline holds while a valid result is stalled.
// Reset (synchronous, active low) clears all valid bits and loads osc = 48 MHz.
`timescale 1ns / 1ps
module baud_divisor_mode_select
    import bdms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [OscW-1:0]   i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out              o_out_data
);

    logic [OscW-1:0]  r_osc;
    logic             r_out_v;
    t_out             r_out;
    t_out             n_out;
    logic             en;

    logic             q_v;
    logic [OscW-1:0]  q_quo;
    logic [BaudW-1:0] q_baud;
    t_side            q_side;

    logic             f_v;
    logic [NumW-1:0]  f_num  [0:Lanes-1];
    logic [MW-1:0]    f_m    [0:Lanes-1];
    t_lane            f_lane [0:Lanes-1];
    t_side            f_side;

    logic             e_v;
    logic [ErrW-1:0]  e_err  [0:Lanes-1];
    t_lane            e_lane [0:Lanes-1];
    t_side            e_side;

    // Hold the oscillator register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_osc <= OSC_RESET;
        end else if (i_cfg_we) begin
            r_osc <= i_cfg_wdata;
        end
    end

    // Advance everything unless a finished result is stalled
    assign en         = !r_out_v || !i_out_stall;
    assign o_in_stall = !en;

    bdms_qdiv u_qdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_osc   (r_osc),
        .o_valid (q_v),
        .o_quo   (q_quo),
        .o_baud  (q_baud),
        .o_side  (q_side)
    );

    bdms_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q_v),
        .i_quo   (q_quo),
        .i_baud  (q_baud),
        .i_side  (q_side),
        .i_osc   (r_osc),
        .o_valid (f_v),
        .o_num   (f_num),
        .o_m     (f_m),
        .o_lane  (f_lane),
        .o_side  (f_side)
    );

    bdms_ediv u_ediv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_v),
        .i_num   (f_num),
        .i_m     (f_m),
        .i_lane  (f_lane),
        .i_side  (f_side),
        .o_valid (e_v),
        .o_err   (e_err),
        .o_lane  (e_lane),
        .o_side  (e_side)
    );

    // Pick the mode: x64 wins ties, x16 and x4 must be strictly better
    always_comb begin
        logic [ErrW-1:0] best;
        logic [DivW-1:0] sel_n;
        t_mode           mode;
        best  = ERR_FULL;
        sel_n = '0;
        mode  = MODE_NONE;
        if (!e_side.zero_baud) begin
            if (e_lane[0].n_ok && e_err[0] <= best) begin
                best = e_err[0]; sel_n = e_lane[0].n; mode = MODE_X64;
            end
            if (e_lane[1].n_ok && e_err[1] < best) begin
                best = e_err[1]; sel_n = e_lane[1].n; mode = MODE_X16;
            end
            if (e_lane[2].n_ok && e_err[2] < best) begin
                best = e_err[2]; sel_n = e_lane[2].n; mode = MODE_X4;
            end
        end
        n_out.config_ok        = (mode != MODE_NONE) && (best <= e_side.limit);
        n_out.brg16_sel        = (mode == MODE_X16) || (mode == MODE_X4);
        n_out.brgh_sel         = (mode == MODE_X4);
        n_out.divisor          = sel_n;
        n_out.error_hundredths = best;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

/* rtl/core/bdms_chk.sv */
// Port-level checker for the baud divisor and mode select block, with its bind.
// Depends on bdms_pkg and the top-level module baud_divisor_mode_select.
`timescale 1ns / 1ps
module bdms_chk
    import bdms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [OscW-1:0]   i_cfg_wdata,
    input  logic              i_in_valid,
    input  logic              o_in_stall,
    input  t_in               i_in_data,
    input  logic              o_out_valid,
    input  logic              i_out_stall,
    input  t_out              o_out_data
);

    // Input side stalls exactly while a result is held back
    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall does not follow output back-pressure");

    // A stalled transaction stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // The x4 prescaler only comes with the 16-bit divisor
    a_mode_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.brgh_sel) |-> o_out_data.brg16_sel)
        else $error("brgh set without brg16");

    // The 8-bit mode never reports a divisor out of its range
    a_div8: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.brg16_sel) |-> (o_out_data.divisor < N8_LIMIT))
        else $error("8-bit divisor out of range");

endmodule

bind baud_divisor_mode_select bdms_chk u_bdms_chk (.*);
